/* sv/pee_pkg.sv */
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants for the precedence expression evaluator
// Token and status codes, stack sizing, sequencer states, ALU request types.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 4;
  localparam int STATUS_W = 3;
  localparam int LEFT_W   = 4;
  localparam int LEVEL_W  = 3;

  localparam int VALUE_DEPTH    = 8;
  localparam int OPERATOR_DEPTH = 8;

  localparam int VIDX_W = $clog2(VALUE_DEPTH);
  localparam int VCNT_W = $clog2(VALUE_DEPTH + 1);
  localparam int OIDX_W = $clog2(OPERATOR_DEPTH);
  localparam int OCNT_W = $clog2(OPERATOR_DEPTH + 1);

  localparam logic [VCNT_W-1:0] VALUE_FULL = VCNT_W'(VALUE_DEPTH);
  localparam logic [OCNT_W-1:0] OPER_FULL  = OCNT_W'(OPERATOR_DEPTH);

  localparam int DIV_CNT_W = $clog2(DATA_W);

  typedef enum logic [KIND_W-1:0] {
    TK_VALUE = 4'd0,
    TK_ADD   = 4'd1,
    TK_SUB   = 4'd2,
    TK_MUL   = 4'd3,
    TK_DIV   = 4'd4,
    TK_AND   = 4'd5,
    TK_OR    = 4'd6,
    TK_SHL   = 4'd7,
    TK_SHR   = 4'd8,
    TK_NEG   = 4'd9,
    TK_LP    = 4'd10,
    TK_RP    = 4'd11,
    TK_END   = 4'd12
  } tok_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_CHECK,
    S_OP_READ,
    S_POP_B,
    S_POP_B_WAIT,
    S_POP_A,
    S_POP_A_WAIT,
    S_EXEC,
    S_EXEC_WAIT,
    S_FINISH,
    S_END_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    tok_kind_t         op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
    logic              div_zero;
  } alu_rsp_t;

  function automatic logic [LEVEL_W-1:0] level_of(tok_kind_t kind);
    case (kind)
      TK_ADD, TK_SUB: return 3'd1;
      TK_MUL, TK_DIV: return 3'd2;
      TK_AND, TK_OR:  return 3'd3;
      TK_SHL, TK_SHR: return 3'd4;
      TK_NEG:         return 3'd5;
      default:        return 3'd0;
    endcase
  endfunction

  // first error wins
  function automatic status_t set_err(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

/* sv/precedence_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// precedence_expression_evaluator: operator-precedence token evaluator
// Value and operator stacks in RAM, reductions run through one shared ALU.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  token     in         token_valid/token_stall    token_kind, token_value
//  result    out        result_valid/result_stall  result_value, eval_status,
//                                                  values_left
//
// Value, negate and left paren tokens are taken straight from idle. Each
// reduction runs operator read, two value pops, ALU and push; negate pops one
// value, and divide by a nonzero divisor runs the 32-step divider. End also
// waits out any result stall and discards left parens. The result register
// frees the input side while a result waits. Reset clears depths and error;
// stack contents need no clear.
// ----------------------------------------------------------------------------
module precedence_expression_evaluator import pee_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     token_valid,
  output logic                     token_stall,
  input  logic [KIND_W-1:0]        token_kind,
  input  logic signed [DATA_W-1:0] token_value,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] result_value,
  output logic [STATUS_W-1:0]      eval_status,
  output logic [LEFT_W-1:0]        values_left
);

  state_t               state, state_next;
  logic [VCNT_W-1:0]    vdepth, vdepth_next;
  logic [OCNT_W-1:0]    odepth, odepth_next;
  status_t              err, err_next;
  tok_kind_t            kind_r, kind_r_next;
  tok_kind_t            op_r, op_r_next;
  logic [LEVEL_W-1:0]   lvl, lvl_next;
  logic [DATA_W-1:0]    a_val, a_val_next;
  logic [DATA_W-1:0]    b_val, b_val_next;
  logic [DATA_W-1:0]    res, res_next;
  logic                 result_valid_next;
  logic                 load_out;

  logic                 v_we;
  logic [VIDX_W-1:0]    v_waddr, v_raddr;
  logic [DATA_W-1:0]    v_wdata, v_rdata;
  logic                 o_we;
  logic [OIDX_W-1:0]    o_waddr, o_raddr;
  logic [KIND_W-1:0]    o_wdata, o_rdata;

  logic [VCNT_W-1:0]    vdepth_m1;
  logic [OCNT_W-1:0]    odepth_m1;
  tok_kind_t            top;
  status_t              e;
  logic                 out_free;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  pee_ram #(.WIDTH(DATA_W), .DEPTH(VALUE_DEPTH)) u_vstack (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  pee_ram #(.WIDTH(KIND_W), .DEPTH(OPERATOR_DEPTH)) u_ostack (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  pee_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign vdepth_m1 = vdepth - 1'b1;
  assign odepth_m1 = odepth - 1'b1;
  assign top       = tok_kind_t'(o_rdata);
  assign out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vdepth       <= '0;
      odepth       <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      vdepth       <= vdepth_next;
      odepth       <= odepth_next;
      err          <= err_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_r_next;
    op_r   <= op_r_next;
    lvl    <= lvl_next;
    a_val  <= a_val_next;
    b_val  <= b_val_next;
    res    <= res_next;
    if (load_out) begin
      result_value <= res;
      eval_status  <= err;
      values_left  <= LEFT_W'(vdepth);
    end
  end

  always_comb begin
    state_next        = state;
    vdepth_next       = vdepth;
    odepth_next       = odepth;
    err_next          = err;
    kind_r_next       = kind_r;
    op_r_next         = op_r;
    lvl_next          = lvl;
    a_val_next        = a_val;
    b_val_next        = b_val;
    res_next          = res;
    result_valid_next = result_valid && result_stall;
    load_out          = 1'b0;
    token_stall       = (state != S_IDLE);
    v_we              = 1'b0;
    v_waddr           = vdepth[VIDX_W-1:0];
    v_wdata           = token_value;
    v_raddr           = '0;
    o_we              = 1'b0;
    o_waddr           = odepth[OIDX_W-1:0];
    o_wdata           = token_kind;
    o_raddr           = odepth_m1[OIDX_W-1:0];
    e                 = err;
    alu_req.start     = 1'b0;
    alu_req.op        = op_r;
    alu_req.a         = a_val;
    alu_req.b         = b_val;

    case (state)
      S_IDLE: begin
        if (token_valid) begin
          kind_r_next = tok_kind_t'(token_kind);
          lvl_next    = level_of(tok_kind_t'(token_kind));
          case (token_kind)
            TK_VALUE: begin
              if (vdepth >= VALUE_FULL) begin
                err_next = set_err(err, ST_OVERFLOW);
              end else begin
                v_we        = 1'b1;
                vdepth_next = vdepth + 1'b1;
              end
            end
            TK_NEG, TK_LP: begin
              if (odepth >= OPER_FULL) begin
                err_next = set_err(err, ST_OVERFLOW);
              end else begin
                o_we        = 1'b1;
                odepth_next = odepth + 1'b1;
              end
            end
            TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_AND, TK_OR, TK_SHL, TK_SHR,
            TK_END: begin
              state_next = S_OP_CHECK;
            end
            TK_RP: begin
              lvl_next   = LEVEL_W'(1);
              state_next = S_OP_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      S_OP_CHECK: begin
        state_next = (odepth == '0) ? S_FINISH : S_OP_READ;
      end
      S_OP_READ: begin
        op_r_next = top;
        if (kind_r == TK_END) begin
          odepth_next = odepth_m1;
          state_next  = (top == TK_LP) ? S_OP_CHECK : S_POP_B;
        end else if (top == TK_LP) begin
          if (kind_r == TK_RP) begin
            odepth_next = odepth_m1;
          end
          state_next = S_FINISH;
        end else if (level_of(top) < lvl) begin
          state_next = S_FINISH;
        end else begin
          odepth_next = odepth_m1;
          state_next  = S_POP_B;
        end
      end
      S_POP_B: begin
        if (vdepth == '0) begin
          err_next   = set_err(err, ST_UNDERFLOW);
          b_val_next = '0;
          state_next = (op_r == TK_NEG) ? S_EXEC : S_POP_A;
        end else begin
          v_raddr     = vdepth_m1[VIDX_W-1:0];
          vdepth_next = vdepth_m1;
          state_next  = S_POP_B_WAIT;
        end
      end
      S_POP_B_WAIT: begin
        b_val_next = v_rdata;
        state_next = (op_r == TK_NEG) ? S_EXEC : S_POP_A;
      end
      S_POP_A: begin
        if (vdepth == '0) begin
          err_next   = set_err(err, ST_UNDERFLOW);
          a_val_next = '0;
          state_next = S_EXEC;
        end else begin
          v_raddr     = vdepth_m1[VIDX_W-1:0];
          vdepth_next = vdepth_m1;
          state_next  = S_POP_A_WAIT;
        end
      end
      S_POP_A_WAIT: begin
        a_val_next = v_rdata;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
        state_next    = S_EXEC_WAIT;
      end
      S_EXEC_WAIT: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div_zero) begin
            e = set_err(e, ST_DIVZERO);
          end
          if (vdepth >= VALUE_FULL) begin
            e = set_err(e, ST_OVERFLOW);
          end else begin
            v_we        = 1'b1;
            v_wdata     = alu_rsp.result;
            vdepth_next = vdepth + 1'b1;
          end
          err_next   = e;
          state_next = S_OP_CHECK;
        end
      end
      S_FINISH: begin
        case (kind_r)
          TK_END: begin
            res_next = '0;
            if (err == ST_OK && vdepth != VCNT_W'(1)) begin
              err_next = ST_MALFORMED;
            end
            state_next = (err == ST_OK && vdepth == VCNT_W'(1)) ? S_END_WAIT : S_OUT;
          end
          TK_RP: begin
            state_next = S_IDLE;
          end
          default: begin
            o_wdata = kind_r;
            if (odepth >= OPER_FULL) begin
              err_next = set_err(err, ST_OVERFLOW);
            end else begin
              o_we        = 1'b1;
              odepth_next = odepth + 1'b1;
            end
            state_next = S_IDLE;
          end
        endcase
      end
      S_END_WAIT: begin
        res_next   = v_rdata;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load_out          = 1'b1;
          result_valid_next = 1'b1;
          vdepth_next       = '0;
          odepth_next       = '0;
          err_next          = ST_OK;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_vdepth_bound: assert property (@(posedge clk) disable iff (rst)
    vdepth <= VALUE_FULL)
    else $error("value depth beyond stack size");

  a_odepth_bound: assert property (@(posedge clk) disable iff (rst)
    odepth <= OPER_FULL)
    else $error("operator depth beyond stack size");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && state != S_OUT) |=> $stable(err))
    else $error("sticky error changed before end");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=>
      (vdepth == '0 && odepth == '0 && err == ST_OK && result_valid))
    else $error("stacks not cleared on result");

  a_alu_idle_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_EXEC_WAIT && !alu_rsp.done) ||
      (alu_req.op != TK_DIV && alu_rsp.done) || state == S_EXEC_WAIT)
    else $error("ALU request not followed by wait");
`endif

endmodule

/* sv/pee_ram.sv */
// ----------------------------------------------------------------------------
// pee_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/pee_alu.sv */
// ----------------------------------------------------------------------------
// pee_alu: shared arithmetic unit
// Registered add/sub/mul/logic/shift/negate results; 32-step restoring divider.
// ----------------------------------------------------------------------------
module pee_alu import pee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dvs;
  logic                 q_neg;
  logic                 done;
  logic                 dz;
  logic [DATA_W-1:0]    result;

  logic [DATA_W-1:0] ma, mb, simple;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DATA_W-1:0] quo_n;
  logic              sat;

  assign ma     = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
  assign mb     = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
  assign sat    = (req.b >= DATA_W'(DATA_W));
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});
  assign quo_n  = {quo[DATA_W-2:0], ge};

  always_comb begin
    case (req.op)
      TK_ADD:  simple = req.a + req.b;
      TK_SUB:  simple = req.a - req.b;
      TK_MUL:  simple = req.a * req.b;
      TK_AND:  simple = req.a & req.b;
      TK_OR:   simple = req.a | req.b;
      TK_SHL:  simple = sat ? '0 : (req.a << req.b[DIV_CNT_W-1:0]);
      TK_SHR:  simple = sat ? {DATA_W{req.a[DATA_W-1]}}
                            : DATA_W'($signed(req.a) >>> req.b[DIV_CNT_W-1:0]);
      TK_NEG:  simple = '0 - req.b;
      default: simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem <= ge ? DATA_W'(rem_sh - {1'b0, dvs}) : rem_sh[DATA_W-1:0];
        quo <= quo_n;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= q_neg ? ('0 - quo_n) : quo_n;
        end
      end else if (req.start) begin
        dz <= 1'b0;
        if (req.op == TK_DIV) begin
          if (req.b == '0) begin
            dz     <= 1'b1;
            result <= '0;
            done   <= 1'b1;
          end else begin
            busy  <= 1'b1;
            rem   <= '0;
            quo   <= ma;
            dvs   <= mb;
            q_neg <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
            cnt   <= DIV_CNT_W'(DATA_W - 1);
          end
        end else begin
          result <= simple;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.result   = result;
  assign rsp.div_zero = dz;

endmodule

/* bench/tb_precedence_expression_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_precedence_expression_evaluator: token stream regression
// Streams directed and random token sequences into the evaluator: well-formed
// expressions with nested parens and negation, stack overflow and underflow
// cases, stray parens and junk tokens. A scoreboard runs its own copy of the
// two-stack reduction and checks every result request field by field, with
// random gaps on the token side and random stalls on the result side.
// ----------------------------------------------------------------------------
import pee_pkg::*;

typedef struct packed {
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] value;
} token_t;

typedef struct {
  logic [DATA_W-1:0] value;
  status_t           status;
  logic [LEFT_W-1:0] left;
} eval_result_t;

class expr_result_board;
  logic [DATA_W-1:0] value_mem [VALUE_DEPTH];
  logic [KIND_W-1:0] oper_mem [OPERATOR_DEPTH];
  int unsigned       value_cnt;
  int unsigned       oper_cnt;
  status_t           first_err;
  eval_result_t      due_results [$];
  int                mismatches;

  function new();
    restart();
    mismatches = 0;
  endfunction

  function void restart();
    value_cnt = 0;
    oper_cnt  = 0;
    first_err = ST_OK;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function void flag(status_t code);
    if (first_err == ST_OK) first_err = code;
  endfunction

  function void push_value(logic [DATA_W-1:0] v);
    if (value_cnt >= VALUE_DEPTH) begin
      flag(ST_OVERFLOW);
      return;
    end
    value_mem[value_cnt] = v;
    value_cnt++;
  endfunction

  function logic [DATA_W-1:0] pop_value();
    if (value_cnt == 0) begin
      flag(ST_UNDERFLOW);
      return '0;
    end
    value_cnt--;
    return value_mem[value_cnt];
  endfunction

  function void push_oper(logic [KIND_W-1:0] kind);
    if (oper_cnt >= OPERATOR_DEPTH) begin
      flag(ST_OVERFLOW);
      return;
    end
    oper_mem[oper_cnt] = kind;
    oper_cnt++;
  endfunction

  function int unsigned rank(logic [KIND_W-1:0] kind);
    case (kind)
      TK_ADD, TK_SUB: return 1;
      TK_MUL, TK_DIV: return 2;
      TK_AND, TK_OR:  return 3;
      TK_SHL, TK_SHR: return 4;
      TK_NEG:         return 5;
      default:        return 0;
    endcase
  endfunction

  // truncating divide on magnitudes; min / -1 wraps back to min
  function logic [DATA_W-1:0] divide(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb, q;
    ma = a[DATA_W-1] ? -a : a;
    mb = b[DATA_W-1] ? -b : b;
    if (b == '0) begin
      flag(ST_DIVZERO);
      return '0;
    end
    q = ma / mb;
    if (a[DATA_W-1] ^ b[DATA_W-1]) return -q;
    return q;
  endfunction

  function logic [DATA_W-1:0] shift(logic [DATA_W-1:0] a, logic [DATA_W-1:0] n, bit to_left);
    logic signed [DATA_W-1:0] s;
    if (n >= DATA_W) begin
      if (to_left) return '0;
      return {DATA_W{a[DATA_W-1]}};
    end
    if (to_left) return a << n;
    s = a;
    s = s >>> n;
    return s;
  endfunction

  function void apply_oper(logic [KIND_W-1:0] kind);
    logic [DATA_W-1:0] a, b;
    if (kind == TK_NEG) begin
      a = pop_value();
      push_value(-a);
      return;
    end
    b = pop_value();
    a = pop_value();
    case (kind)
      TK_ADD:  push_value(a + b);
      TK_SUB:  push_value(a - b);
      TK_MUL:  push_value(a * b);
      TK_DIV:  push_value(divide(a, b));
      TK_AND:  push_value(a & b);
      TK_OR:   push_value(a | b);
      TK_SHL:  push_value(shift(a, b, 1'b1));
      TK_SHR:  push_value(shift(a, b, 1'b0));
      default: ;
    endcase
  endfunction

  function void fold_down(int unsigned lvl);
    logic [KIND_W-1:0] top;
    while (oper_cnt > 0) begin
      top = oper_mem[oper_cnt - 1];
      if (top == TK_LP || rank(top) < lvl) return;
      oper_cnt--;
      apply_oper(top);
    end
  endfunction

  function void note_token(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
    eval_result_t r;
    case (kind)
      TK_VALUE: push_value(value);
      TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_AND, TK_OR, TK_SHL, TK_SHR: begin
        fold_down(rank(kind));
        push_oper(kind);
      end
      TK_NEG, TK_LP: push_oper(kind);
      TK_RP: begin
        fold_down(1);
        if (oper_cnt > 0 && oper_mem[oper_cnt - 1] == TK_LP) oper_cnt--;
      end
      TK_END: begin
        while (oper_cnt > 0) begin
          oper_cnt--;
          if (oper_mem[oper_cnt] != TK_LP) apply_oper(oper_mem[oper_cnt]);
        end
        r.status = first_err;
        if (r.status == ST_OK && value_cnt != 1) r.status = ST_MALFORMED;
        r.value = (r.status == ST_OK) ? value_mem[0] : '0;
        r.left  = LEFT_W'(value_cnt);
        due_results.push_back(r);
        restart();
      end
      default: ;
    endcase
  endfunction

  task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t mismatch on %0s: got %0h, want %0h", $time, what, got, want);
  endtask

  task check_result(logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
                    logic [LEFT_W-1:0] left);
    eval_result_t want;
    if (due_results.size() == 0) begin
      report("result with none due", value, '0);
      return;
    end
    want = due_results.pop_front();
    if (value !== want.value) report("result_value", value, want.value);
    if (status !== want.status)
      report("eval_status", DATA_W'(status), DATA_W'(want.status));
    if (left !== want.left) report("values_left", DATA_W'(left), DATA_W'(want.left));
  endtask
endclass

module tb_precedence_expression_evaluator;

  localparam int TOTAL_ITEMS    = 1100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 50;

  localparam logic [KIND_W-1:0] TK_SPARE_FIRST = 4'd13;
  localparam logic [KIND_W-1:0] TK_SPARE_LAST  = 4'd15;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     token_valid = 1'b0;
  logic                     token_stall;
  logic [KIND_W-1:0]        token_kind = '0;
  logic signed [DATA_W-1:0] token_value = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      eval_status;
  logic [LEFT_W-1:0]        values_left;

  expr_result_board board;
  token_t           token_plan [$];
  int unsigned      sent_count = 0;
  int unsigned      stall_run = 0;
  int unsigned      idle_cycles = 0;
  bit               tx_steady = 1'b0;
  bit               rx_stalls = 1'b1;

  precedence_expression_evaluator u_top (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .eval_status  (eval_status),
    .values_left  (values_left)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        board.check_result(result_value, eval_status, values_left);
      if (token_valid && !token_stall) board.note_token(token_kind, token_value);
    end
  end

  always @(posedge clk) begin
    if (stall_run > 0) stall_run--;
    else if (rx_stalls && $urandom_range(0, 3) == 0)
      stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 4);
    result_stall <= (stall_run > 0);
  end

  always @(posedge clk) begin
    if (rst || (token_valid && !token_stall) || (result_valid && !result_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 40);
      4: return -$urandom_range(1, 40);
      5: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return '1;
          default: return '0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic plan(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    token_t t;
    t.kind  = kind;
    t.value = value;
    token_plan.push_back(t);
  endtask

  task automatic plan_operand(input int nest);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) plan(TK_NEG, $urandom());
    if (nest < 2 && $urandom_range(0, 4) == 0) begin
      plan(TK_LP, $urandom());
      plan_expr(nest + 1);
      plan(TK_RP, $urandom());
    end else begin
      plan(TK_VALUE, rand_operand());
    end
  endtask

  task automatic plan_expr(input int nest);
    int unsigned terms;
    terms = $urandom_range(1, 4);
    plan_operand(nest);
    repeat (terms - 1) begin
      plan(KIND_W'($urandom_range(TK_ADD, TK_SHR)), $urandom());
      plan_operand(nest);
    end
  endtask

  task automatic plan_corner();
    case ($urandom_range(0, 4))
      0: repeat (VALUE_DEPTH + $urandom_range(0, 2)) plan(TK_VALUE, rand_operand());
      1: begin
        repeat (OPERATOR_DEPTH + 1) plan(TK_LP, $urandom());
        plan(TK_VALUE, rand_operand());
      end
      2: begin
        plan(TK_VALUE, rand_operand());
        plan(KIND_W'($urandom_range(TK_ADD, TK_SHR)), $urandom());
        plan(KIND_W'($urandom_range(TK_ADD, TK_SHR)), $urandom());
        plan(TK_VALUE, rand_operand());
      end
      3: begin
        plan(TK_RP, $urandom());
        plan_expr(0);
        repeat ($urandom_range(1, 3)) plan(TK_RP, $urandom());
      end
      default: begin
        plan(TK_LP, $urandom());
        plan_expr(0);
      end
    endcase
    plan(TK_END, $urandom());
  endtask

  task automatic plan_noise();
    repeat ($urandom_range(1, 8))
      plan(KIND_W'($urandom_range(0, (1 << KIND_W) - 1)), $urandom());
    plan(TK_END, $urandom());
  endtask

  // valid stays high across back-to-back requests; it drops only for a gap
  task automatic send_plan();
    token_t      t;
    int unsigned gap;
    while (token_plan.size() > 0) begin
      t   = token_plan.pop_front();
      gap = pick_gap();
      if (gap > 0) begin
        token_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      token_valid <= 1'b1;
      token_kind  <= t.kind;
      token_value <= t.value;
      @(posedge clk);
      while (token_stall) @(posedge clk);
      sent_count++;
    end
  endtask

  task automatic hold_until_drained();
    token_valid <= 1'b0;
    do @(posedge clk); while (board.pending() > 0);
  endtask

  initial begin
    int unsigned pick;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    plan(TK_END, '0);
    plan(TK_VALUE, 32'h8000_0000);
    plan(TK_DIV, '0);
    plan(TK_VALUE, '1);
    plan(TK_END, '0);
    plan(TK_NEG, '0);
    plan(TK_NEG, '0);
    plan(TK_NEG, '0);
    plan(TK_VALUE, 7);
    plan(TK_SHR, '0);
    plan(TK_VALUE, 40);
    plan(TK_END, '0);
    plan(TK_VALUE, 9);
    plan(TK_DIV, '0);
    plan(TK_VALUE, 0);
    plan(TK_END, '0);
    plan(TK_RP, '0);
    plan(TK_VALUE, 6);
    plan(TK_MUL, '0);
    plan(TK_VALUE, -2);
    plan(TK_OR, '0);
    plan(TK_VALUE, 1);
    plan(TK_RP, '0);
    plan(TK_END, '0);
    plan(TK_LP, '0);
    plan(TK_VALUE, 1);
    plan(TK_ADD, '0);
    plan(TK_VALUE, 32'h7fff_ffff);
    plan(TK_END, '0);
    plan(TK_VALUE, 4);
    plan(TK_SPARE_FIRST, '1);
    plan(TK_VALUE, 5);
    plan(TK_SPARE_LAST, '1);
    plan(TK_END, '0);
    plan(TK_SUB, '0);
    plan(TK_END, '0);
    send_plan();
    hold_until_drained();

    while (sent_count < TOTAL_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_stalls = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        plan_expr(0);
        plan(TK_END, $urandom());
      end else if (pick < 85) begin
        plan_corner();
      end else begin
        plan_noise();
      end
      send_plan();
      if ($urandom_range(0, 29) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
